// ===== src/dpfrc_pkg.sv =====
// Package with the constants, types and helper functions shared by the packet buffer modules.
package dpfrc_pkg;

    localparam int DEPTH   = 256;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int FILL_W  = IDX_W + 1;
    localparam int SRC_W   = 20;
    localparam int DST_W   = 20;
    localparam int TIME_W  = 30;
    localparam int CNT_W   = 9;
    localparam int LIMIT_W = 9;
    localparam int OP_W    = 2;

    localparam logic [CNT_W-1:0]  COUNT_MAX     = '1;
    localparam logic [IDX_W-1:0]  LAST_IDX      = IDX_W'(DEPTH - 1);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET  = LIMIT_W'(256);

    typedef enum logic [OP_W-1:0] {
        OP_ADD     = 2'd0,
        OP_FORWARD = 2'd1,
        OP_COUNT   = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [SRC_W-1:0]  source;
        logic [DST_W-1:0]  destination;
        logic [TIME_W-1:0] timestamp;
    } entry_t;

    typedef struct packed {
        logic load;
        logic start_scan;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_busy;
        logic out_free;
    } ctrl_sts_t;

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] r;
        if (i == LAST_IDX)
        begin
            r = '0;
        end
        else
        begin
            r = i + 1'b1;
        end
        return r;
    endfunction

endpackage

// ===== src/dedup_packet_fifo_range_count.sv =====
// Top level of the packet buffer with duplicate check and range count.
// An accepted item is loaded, then a scan reads the stored entries in turn, then the result is registered;
// add and count scan every stored entry, and forward of a nonempty buffer reads only the head entry.
// One item is in work at a time, so the next item is accepted only after the last one's result is
// registered, and no result is registered while an earlier result still waits on out_stall.
// Reset clears the pointers and fill count and sets the limit to 256; the memory is not cleared.
module dedup_packet_fifo_range_count (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [dpfrc_pkg::OP_W-1:0]        op,
    input  logic [dpfrc_pkg::SRC_W-1:0]       source,
    input  logic [dpfrc_pkg::DST_W-1:0]       destination,
    input  logic [dpfrc_pkg::TIME_W-1:0]      timestamp,
    input  logic [dpfrc_pkg::TIME_W-1:0]      start_time,
    input  logic [dpfrc_pkg::TIME_W-1:0]      end_time,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dpfrc_pkg::LIMIT_W-1:0]     memory_limit,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              added,
    output logic                              forward_valid,
    output logic [dpfrc_pkg::SRC_W-1:0]       out_source,
    output logic [dpfrc_pkg::DST_W-1:0]       out_destination,
    output logic [dpfrc_pkg::TIME_W-1:0]      out_timestamp,
    output logic [dpfrc_pkg::CNT_W-1:0]       match_count
);
    import dpfrc_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    assign cfg_ready = 1'b1;

    dpfrc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    dpfrc_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .op              (op),
        .source          (source),
        .destination     (destination),
        .timestamp       (timestamp),
        .start_time      (start_time),
        .end_time        (end_time),
        .cfg_write       (cfg_valid && cfg_ready),
        .cfg_limit       (memory_limit),
        .cmd             (cmd),
        .sts             (sts),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .added           (added),
        .forward_valid   (forward_valid),
        .out_source      (out_source),
        .out_destination (out_destination),
        .out_timestamp   (out_timestamp),
        .match_count     (match_count)
    );

endmodule

// ===== src/dpfrc_ctrl.sv =====
// Controller state machine that sequences load, scan and finish for each item.
module dpfrc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  dpfrc_pkg::ctrl_sts_t sts,
    output dpfrc_pkg::ctrl_cmd_t cmd
);
    import dpfrc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                cmd.start_scan = 1'b1;
                state_next     = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (!sts.scan_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/dpfrc_datapath.sv =====
// Datapath with the entry memory, queue pointers, scan unit and result register.
module dpfrc_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [dpfrc_pkg::OP_W-1:0]        op,
    input  logic [dpfrc_pkg::SRC_W-1:0]       source,
    input  logic [dpfrc_pkg::DST_W-1:0]       destination,
    input  logic [dpfrc_pkg::TIME_W-1:0]      timestamp,
    input  logic [dpfrc_pkg::TIME_W-1:0]      start_time,
    input  logic [dpfrc_pkg::TIME_W-1:0]      end_time,
    input  logic                              cfg_write,
    input  logic [dpfrc_pkg::LIMIT_W-1:0]     cfg_limit,
    input  dpfrc_pkg::ctrl_cmd_t              cmd,
    output dpfrc_pkg::ctrl_sts_t              sts,
    input  logic                              out_stall,
    output logic                              out_valid,
    output logic                              added,
    output logic                              forward_valid,
    output logic [dpfrc_pkg::SRC_W-1:0]       out_source,
    output logic [dpfrc_pkg::DST_W-1:0]       out_destination,
    output logic [dpfrc_pkg::TIME_W-1:0]      out_timestamp,
    output logic [dpfrc_pkg::CNT_W-1:0]       match_count
);
    import dpfrc_pkg::*;

    entry_t mem [DEPTH];

    logic [OP_W-1:0]    op_reg;
    logic [SRC_W-1:0]   src_reg;
    logic [DST_W-1:0]   dst_reg;
    logic [TIME_W-1:0]  ts_reg;
    logic [TIME_W-1:0]  lo_reg;
    logic [TIME_W-1:0]  hi_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [IDX_W-1:0]   head_reg;
    logic [IDX_W-1:0]   tail_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic [IDX_W-1:0]   scan_ptr_reg;
    logic [FILL_W-1:0]  scan_left_reg;
    logic [FILL_W-1:0]  scan_left_next;
    logic               rd_valid_reg;
    entry_t             rd_data_reg;
    logic               dup_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               out_valid_reg;
    logic               added_reg;
    logic               fwd_valid_reg;
    logic [SRC_W-1:0]   out_src_reg;
    logic [DST_W-1:0]   out_dst_reg;
    logic [TIME_W-1:0]  out_ts_reg;
    logic [CNT_W-1:0]   out_cnt_reg;

    logic              issue;
    logic              triple_hit;
    logic              range_hit;
    logic [FILL_W-1:0] eff_limit;
    logic              evict;
    logic              do_write;

    assign issue      = (scan_left_reg != '0);
    assign triple_hit = (rd_data_reg.source == src_reg) &&
                        (rd_data_reg.destination == dst_reg) &&
                        (rd_data_reg.timestamp == ts_reg);
    assign range_hit  = (rd_data_reg.destination == dst_reg) &&
                        (rd_data_reg.timestamp >= lo_reg) &&
                        (rd_data_reg.timestamp <= hi_reg);

    always_comb
    begin
        if (limit_reg == '0)
        begin
            eff_limit = FILL_W'(1);
        end
        else if (32'(limit_reg) > 32'(DEPTH))
        begin
            eff_limit = FILL_W'(DEPTH);
        end
        else
        begin
            eff_limit = FILL_W'(limit_reg);
        end
    end

    assign evict    = (fill_reg >= eff_limit) && (fill_reg != '0);
    assign do_write = cmd.finish && (op_reg == OP_ADD) && !dup_reg;

    always_comb
    begin
        case (op_reg)
            OP_ADD:     scan_left_next = fill_reg;
            OP_COUNT:   scan_left_next = fill_reg;
            OP_FORWARD: scan_left_next = (fill_reg != '0) ? FILL_W'(1) : '0;
            default:    scan_left_next = '0;
        endcase
    end

    assign sts.scan_busy = issue || rd_valid_reg;
    assign sts.out_free  = !out_valid_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[tail_reg] <= '{source: src_reg, destination: dst_reg, timestamp: ts_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_data_reg <= mem[scan_ptr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= op;
            src_reg <= source;
            dst_reg <= destination;
            ts_reg  <= timestamp;
            lo_reg  <= start_time;
            hi_reg  <= end_time;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            limit_reg <= cfg_limit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_ptr_reg  <= '0;
            scan_left_reg <= '0;
            rd_valid_reg  <= 1'b0;
            dup_reg       <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            rd_valid_reg <= issue;
            if (cmd.start_scan)
            begin
                scan_ptr_reg  <= head_reg;
                scan_left_reg <= scan_left_next;
                dup_reg       <= 1'b0;
                cnt_reg       <= '0;
            end
            else
            begin
                if (issue)
                begin
                    scan_ptr_reg  <= next_idx(scan_ptr_reg);
                    scan_left_reg <= scan_left_reg - 1'b1;
                end
                if (rd_valid_reg)
                begin
                    if (triple_hit)
                    begin
                        dup_reg <= 1'b1;
                    end
                    if (range_hit && (cnt_reg < COUNT_MAX))
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end
        else if (cmd.finish)
        begin
            case (op_reg)
                OP_ADD:
                begin
                    if (!dup_reg)
                    begin
                        tail_reg <= next_idx(tail_reg);
                        if (evict)
                        begin
                            head_reg <= next_idx(head_reg);
                        end
                        else
                        begin
                            fill_reg <= fill_reg + 1'b1;
                        end
                    end
                end
                OP_FORWARD:
                begin
                    if (fill_reg != '0)
                    begin
                        head_reg <= next_idx(head_reg);
                        fill_reg <= fill_reg - 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            added_reg     <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_src_reg   <= '0;
            out_dst_reg   <= '0;
            out_ts_reg    <= '0;
            out_cnt_reg   <= '0;
            case (op_reg)
                OP_ADD:
                begin
                    added_reg <= !dup_reg;
                end
                OP_FORWARD:
                begin
                    if (fill_reg != '0)
                    begin
                        fwd_valid_reg <= 1'b1;
                        out_src_reg   <= rd_data_reg.source;
                        out_dst_reg   <= rd_data_reg.destination;
                        out_ts_reg    <= rd_data_reg.timestamp;
                    end
                end
                OP_COUNT:
                begin
                    out_cnt_reg <= cnt_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign added           = added_reg;
    assign forward_valid   = fwd_valid_reg;
    assign out_source      = out_src_reg;
    assign out_destination = out_dst_reg;
    assign out_timestamp   = out_ts_reg;
    assign match_count     = out_cnt_reg;

endmodule

// ===== src/dpfrc_checker.sv =====
// Checker on the top-level ports of the packet buffer, with its bind statement.
module dpfrc_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic                              added,
    input logic                              forward_valid,
    input logic [dpfrc_pkg::SRC_W-1:0]       out_source,
    input logic [dpfrc_pkg::DST_W-1:0]       out_destination,
    input logic [dpfrc_pkg::TIME_W-1:0]      out_timestamp,
    input logic [dpfrc_pkg::CNT_W-1:0]       match_count
);
    import dpfrc_pkg::*;

    // The block works on one item at a time, so an accepted item stalls the input next cycle.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after an accepted item");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(added) && $stable(forward_valid) &&
        $stable(out_source) && $stable(match_count))
        else $error("stalled result changed");

    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(added && forward_valid) &&
        ((match_count == '0) || (!added && !forward_valid)))
        else $error("result carries more than one kind of answer");

    a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !forward_valid |-> (out_source == '0) && (out_destination == '0) &&
        (out_timestamp == '0))
        else $error("packet fields nonzero without a forwarded packet");

endmodule

bind dedup_packet_fifo_range_count dpfrc_checker u_dpfrc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .added           (added),
    .forward_valid   (forward_valid),
    .out_source      (out_source),
    .out_destination (out_destination),
    .out_timestamp   (out_timestamp),
    .match_count     (match_count)
);
